>>> rtl/core/assert_macros.svh
// assertion helpers used by the rtl core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge out of reset
`define WSD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// condition that must never hold out of reset
`define WSD_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

>>> rtl/core/wsd_pkg.sv
package wsd_pkg;

  localparam logic [2:0] PH_HDR0 = 3'd0;
  localparam logic [2:0] PH_HDR1 = 3'd1;
  localparam logic [2:0] PH_EXT  = 3'd2;
  localparam logic [2:0] PH_MASK = 3'd3;
  localparam logic [2:0] PH_DATA = 3'd4;
  localparam logic [2:0] PH_SKIP = 3'd5;

  localparam logic [2:0] EV_DATA     = 3'd0;
  localparam logic [2:0] EV_EMPTY    = 3'd1;
  localparam logic [2:0] EV_PONG     = 3'd2;
  localparam logic [2:0] EV_CLOSE    = 3'd3;
  localparam logic [2:0] EV_OVERSIZE = 3'd4;

  localparam logic [3:0] OPC_MASK  = 4'h0F;
  localparam logic [3:0] OPC_CLOSE = 4'h8;
  localparam logic [3:0] OPC_PING  = 4'h9;
  localparam logic [7:0] PONG_HDR0 = 8'h80 | 8'h0A;
  localparam logic [7:0] PONG_HDR1 = 8'h00;
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  localparam logic [15:0] MAX_PAYLOAD_RST = 16'hFFFF;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [7:0]  out_byte;
    logic        last;
    logic [3:0]  frame_opcode;
    logic [15:0] message_length;
  } res_t;

endpackage

>>> rtl/core/wsd_if.sv
interface wsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       restart;

  modport source (output valid, output rx_byte, output restart, input ready);
  modport sink (input valid, input rx_byte, input restart, output ready);
endinterface

interface wsd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_kind;
  logic [7:0]  out_byte;
  logic        last;
  logic [3:0]  frame_opcode;
  logic [15:0] message_length;

  modport source (output valid, output event_kind, output out_byte, output last,
                  output frame_opcode, output message_length, input ready);
  modport sink (input valid, input event_kind, input out_byte, input last,
                input frame_opcode, input message_length, output ready);
endinterface

>>> rtl/core/websocket_frame_deframer_core.sv
// a result word is written into the result queue when its input word is accepted
// throughput: one input word per cycle while in_ch.ready is high; a ping header pushes
//   two pong words, which leave the four-entry result queue one after the other
// the input stalls only while fewer than two entries of the result queue are free
// reset: synchronous active-low rst_n clears the parser, the queue and sets
//   max_payload to 65535
`include "assert_macros.svh"

module websocket_frame_deframer_core (
  input  logic           clk,
  input  logic           rst_n,
  wsd_in_if.sink         in_ch,
  wsd_out_if.source      out_ch,
  input  logic           cfg_we,
  input  logic [15:0]    cfg_data
);

  logic [15:0] max_payload_r;

  logic [2:0]  phase_r, phase_nxt;
  logic        stopped_r, stopped_nxt;
  logic [2:0]  ext_cnt_r, ext_cnt_nxt;
  logic [3:0]  opcode_r, opcode_nxt;
  logic        mask_flag_r, mask_flag_nxt;
  logic [63:0] length_r, length_nxt;
  logic [63:0] remain_r, remain_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic [31:0] mask_key_r, mask_key_nxt;

  wsd_pkg::res_t          queue_r [wsd_pkg::QDEPTH];
  logic [wsd_pkg::QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [wsd_pkg::QAW:0]   count_r;

  logic          acc, pop;
  logic [1:0]    push_n;
  wsd_pkg::res_t res0, res1;
  logic [2:0]    phase_e;
  logic          stopped_e;
  logic          hd_go;
  logic [7:0]    key_byte;
  logic [6:0]    l7;
  logic          stopped_acc;
  logic          data_end;

  assign in_ch.ready = (count_r <= (wsd_pkg::QAW+1)'(wsd_pkg::QDEPTH - 2));
  assign acc         = in_ch.valid && in_ch.ready;
  assign pop         = out_ch.valid && out_ch.ready;

  always_comb begin
    unique case (idx_r)
      2'd0: key_byte = mask_key_r[31:24];
      2'd1: key_byte = mask_key_r[23:16];
      2'd2: key_byte = mask_key_r[15:8];
      default: key_byte = mask_key_r[7:0];
    endcase
  end

  assign l7 = in_ch.rx_byte[6:0];

  always_comb begin
    phase_e   = in_ch.restart ? wsd_pkg::PH_HDR0 : phase_r;
    stopped_e = in_ch.restart ? 1'b0 : stopped_r;

    phase_nxt     = phase_e;
    stopped_nxt   = stopped_e;
    ext_cnt_nxt   = in_ch.restart ? 3'd0 : ext_cnt_r;
    opcode_nxt    = in_ch.restart ? 4'd0 : opcode_r;
    mask_flag_nxt = in_ch.restart ? 1'b0 : mask_flag_r;
    length_nxt    = in_ch.restart ? 64'd0 : length_r;
    remain_nxt    = in_ch.restart ? 64'd0 : remain_r;
    idx_nxt       = in_ch.restart ? 2'd0 : idx_r;
    mask_key_nxt  = in_ch.restart ? 32'd0 : mask_key_r;

    hd_go  = 1'b0;
    push_n = 2'd0;
    res0   = '0;
    res1   = '0;

    if (!stopped_e) begin
      unique case (phase_e)
        wsd_pkg::PH_HDR0: begin
          opcode_nxt = in_ch.rx_byte[3:0] & wsd_pkg::OPC_MASK;
          phase_nxt  = wsd_pkg::PH_HDR1;
        end
        wsd_pkg::PH_HDR1: begin
          mask_flag_nxt = in_ch.rx_byte[7];
          mask_key_nxt  = 32'd0;
          length_nxt    = 64'd0;
          if (l7 == wsd_pkg::LEN_EXT16) begin
            ext_cnt_nxt = 3'd1;
            phase_nxt   = wsd_pkg::PH_EXT;
          end else if (l7 == wsd_pkg::LEN_EXT64) begin
            ext_cnt_nxt = 3'd7;
            phase_nxt   = wsd_pkg::PH_EXT;
          end else begin
            length_nxt = {57'd0, l7};
            if (mask_flag_nxt) begin
              ext_cnt_nxt = 3'd3;
              phase_nxt   = wsd_pkg::PH_MASK;
            end else begin
              hd_go = 1'b1;
            end
          end
        end
        wsd_pkg::PH_EXT: begin
          length_nxt = {length_r[55:0], in_ch.rx_byte};
          if (ext_cnt_r == 3'd0) begin
            if (mask_flag_r) begin
              ext_cnt_nxt = 3'd3;
              phase_nxt   = wsd_pkg::PH_MASK;
            end else begin
              hd_go = 1'b1;
            end
          end else begin
            ext_cnt_nxt = ext_cnt_r - 3'd1;
          end
        end
        wsd_pkg::PH_MASK: begin
          mask_key_nxt = {mask_key_r[23:0], in_ch.rx_byte};
          if (ext_cnt_r == 3'd0) begin
            hd_go = 1'b1;
          end else begin
            ext_cnt_nxt = ext_cnt_r - 3'd1;
          end
        end
        wsd_pkg::PH_DATA: begin
          push_n              = 2'd1;
          res0.event_kind     = wsd_pkg::EV_DATA;
          res0.out_byte       = in_ch.rx_byte ^ (mask_flag_r ? key_byte : 8'd0);
          res0.last           = (remain_r == 64'd1);
          res0.frame_opcode   = opcode_r;
          res0.message_length = length_r[15:0];
          idx_nxt             = idx_r + 2'd1;
          remain_nxt          = remain_r - 64'd1;
          if (remain_r == 64'd1) begin
            phase_nxt = wsd_pkg::PH_HDR0;
          end
        end
        wsd_pkg::PH_SKIP: begin
          remain_nxt = remain_r - 64'd1;
          if (remain_r == 64'd1) begin
            phase_nxt = wsd_pkg::PH_HDR0;
          end
        end
        default: begin
          phase_nxt = wsd_pkg::PH_HDR0;
        end
      endcase

      if (hd_go) begin
        idx_nxt           = 2'd0;
        remain_nxt        = length_nxt;
        push_n            = 2'd1;
        res0.frame_opcode = opcode_nxt;
        phase_nxt         = wsd_pkg::PH_HDR0;
        priority if (opcode_nxt == wsd_pkg::OPC_CLOSE) begin
          res0.event_kind = wsd_pkg::EV_CLOSE;
          stopped_nxt     = 1'b1;
        end else if (opcode_nxt == wsd_pkg::OPC_PING) begin
          push_n            = 2'd2;
          res0.event_kind   = wsd_pkg::EV_PONG;
          res0.out_byte     = wsd_pkg::PONG_HDR0;
          res1.event_kind   = wsd_pkg::EV_PONG;
          res1.out_byte     = wsd_pkg::PONG_HDR1;
          res1.last         = 1'b1;
          res1.frame_opcode = opcode_nxt;
          if (length_nxt != 64'd0) begin
            phase_nxt = wsd_pkg::PH_SKIP;
          end
        end else if (length_nxt > {48'd0, max_payload_r}) begin
          res0.event_kind = wsd_pkg::EV_OVERSIZE;
          stopped_nxt     = 1'b1;
        end else if (length_nxt == 64'd0) begin
          res0.event_kind = wsd_pkg::EV_EMPTY;
        end else begin
          push_n    = 2'd0;
          phase_nxt = wsd_pkg::PH_DATA;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= wsd_pkg::MAX_PAYLOAD_RST;
    end else if (cfg_we) begin
      max_payload_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= wsd_pkg::PH_HDR0;
      stopped_r   <= 1'b0;
      ext_cnt_r   <= 3'd0;
      opcode_r    <= 4'd0;
      mask_flag_r <= 1'b0;
      length_r    <= 64'd0;
      remain_r    <= 64'd0;
      idx_r       <= 2'd0;
      mask_key_r  <= 32'd0;
    end else if (acc) begin
      phase_r     <= phase_nxt;
      stopped_r   <= stopped_nxt;
      ext_cnt_r   <= ext_cnt_nxt;
      opcode_r    <= opcode_nxt;
      mask_flag_r <= mask_flag_nxt;
      length_r    <= length_nxt;
      remain_r    <= remain_nxt;
      idx_r       <= idx_nxt;
      mask_key_r  <= mask_key_nxt;
    end
  end

  // result queue
  always_ff @(posedge clk) begin
    if (acc && (push_n != 2'd0)) begin
      queue_r[wr_ptr_r] <= res0;
    end
    if (acc && (push_n == 2'd2)) begin
      queue_r[wr_ptr_r + wsd_pkg::QAW'(1)] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (acc) begin
        wr_ptr_r <= wr_ptr_r + wsd_pkg::QAW'(push_n);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + wsd_pkg::QAW'(1);
      end
      count_r <= count_r + (acc ? (wsd_pkg::QAW+1)'(push_n) : '0)
                 - (pop ? (wsd_pkg::QAW+1)'(1) : '0);
    end
  end

  assign out_ch.valid          = (count_r != '0);
  assign out_ch.event_kind     = queue_r[rd_ptr_r].event_kind;
  assign out_ch.out_byte       = queue_r[rd_ptr_r].out_byte;
  assign out_ch.last           = queue_r[rd_ptr_r].last;
  assign out_ch.frame_opcode   = queue_r[rd_ptr_r].frame_opcode;
  assign out_ch.message_length = queue_r[rd_ptr_r].message_length;

  assign stopped_acc = acc && stopped_r && !in_ch.restart;
  assign data_end    = acc && !stopped_e && (phase_e == wsd_pkg::PH_DATA) &&
                       (remain_r == 64'd1);

  `WSD_NEVER(a_queue_overflow, clk, rst_n, count_r > (wsd_pkg::QAW+1)'(wsd_pkg::QDEPTH))
  `WSD_ASSERT(a_stopped_silent, clk, rst_n, stopped_acc |-> (push_n == 2'd0))
  `WSD_ASSERT(a_pair_is_pong, clk, rst_n, push_n == 2'd2 |-> res0.event_kind == wsd_pkg::EV_PONG)
  `WSD_ASSERT(a_frame_end, clk, rst_n, data_end |=> (phase_r == wsd_pkg::PH_HDR0))

endmodule

>>> tb/deframe_monitor.sv
`timescale 1ns / 1ps

module deframe_monitor
  import wsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  wsd_in_if           in_mon,
  wsd_out_if          out_mon,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  output int          errors,
  output int          outstanding
);

  // parser state mirrored from the block
  logic [2:0]  phase;
  logic [2:0]  ext_left;
  logic [3:0]  opcode;
  logic        masked;
  logic [63:0] frame_len;
  logic [63:0] byte_idx;
  logic [31:0] key;
  logic        halted;
  logic [15:0] max_len;

  res_t expected_words[$];

  task automatic report_error(input string msg);
    $display("[%0t] error: %s", $time, msg);
    errors++;
  endtask

  task automatic compare_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
    if (got !== want)
      report_error($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
  endtask

  task automatic emit_word(input logic [2:0] kind, input logic [7:0] b, input logic lst,
                           input logic [15:0] len);
    res_t w;
    w.event_kind     = kind;
    w.out_byte       = b;
    w.last           = lst;
    w.frame_opcode   = opcode;
    w.message_length = len;
    expected_words.push_back(w);
  endtask

  task automatic clear_parser();
    phase     = PH_HDR0;
    ext_left  = '0;
    opcode    = '0;
    masked    = 1'b0;
    frame_len = '0;
    byte_idx  = '0;
    key       = '0;
    halted    = 1'b0;
  endtask

  task automatic finish_header();
    byte_idx = '0;
    if (opcode == OPC_CLOSE) begin
      emit_word(EV_CLOSE, 8'h00, 1'b0, 16'h0000);
      halted = 1'b1;
      phase  = PH_HDR0;
    end else if (opcode == OPC_PING) begin
      emit_word(EV_PONG, PONG_HDR0, 1'b0, 16'h0000);
      emit_word(EV_PONG, PONG_HDR1, 1'b1, 16'h0000);
      phase = (frame_len != 0) ? PH_SKIP : PH_HDR0;
    end else if (frame_len > {48'd0, max_len}) begin
      emit_word(EV_OVERSIZE, 8'h00, 1'b0, 16'h0000);
      halted = 1'b1;
      phase  = PH_HDR0;
    end else if (frame_len == 0) begin
      emit_word(EV_EMPTY, 8'h00, 1'b0, 16'h0000);
      phase = PH_HDR0;
    end else begin
      phase = PH_DATA;
    end
  endtask

  task automatic length_done();
    if (masked) begin
      ext_left = 3'd3;
      phase    = PH_MASK;
    end else begin
      finish_header();
    end
  endtask

  task automatic advance_parser(input logic [7:0] b, input logic rs);
    logic [6:0]  l7;
    int unsigned sh;
    logic [7:0]  kb;
    if (rs) clear_parser();
    if (!halted) begin
      case (phase)
        PH_HDR0: begin
          opcode = b[3:0] & OPC_MASK;
          phase  = PH_HDR1;
        end
        PH_HDR1: begin
          l7        = b[6:0];
          masked    = b[7];
          key       = '0;
          frame_len = '0;
          if (l7 == LEN_EXT16) begin
            ext_left = 3'd1;
            phase    = PH_EXT;
          end else if (l7 == LEN_EXT64) begin
            ext_left = 3'd7;
            phase    = PH_EXT;
          end else begin
            frame_len = {57'd0, l7};
            length_done();
          end
        end
        PH_EXT: begin
          frame_len = {frame_len[55:0], b};
          if (ext_left == 0) length_done();
          else ext_left = ext_left - 3'd1;
        end
        PH_MASK: begin
          key = {key[23:0], b};
          if (ext_left == 0) finish_header();
          else ext_left = ext_left - 3'd1;
        end
        PH_DATA: begin
          sh = 24 - 8 * int'(byte_idx[1:0]);
          kb = masked ? 8'(key >> sh) : 8'h00;
          emit_word(EV_DATA, b ^ kb, (byte_idx + 64'd1 == frame_len), frame_len[15:0]);
          byte_idx = byte_idx + 64'd1;
          if (byte_idx >= frame_len) phase = PH_HDR0;
        end
        PH_SKIP: begin
          byte_idx = byte_idx + 64'd1;
          if (byte_idx >= frame_len) phase = PH_HDR0;
        end
        default: phase = PH_HDR0;
      endcase
    end
  endtask

  task automatic check_word();
    res_t want;
    if (expected_words.size() == 0) begin
      report_error($sformatf("unexpected word kind %0d byte 0x%0h",
                             out_mon.event_kind, out_mon.out_byte));
    end else begin
      want = expected_words.pop_front();
      compare_field("event_kind", 16'(out_mon.event_kind), 16'(want.event_kind));
      compare_field("out_byte", 16'(out_mon.out_byte), 16'(want.out_byte));
      compare_field("last", 16'(out_mon.last), 16'(want.last));
      compare_field("frame_opcode", 16'(out_mon.frame_opcode), 16'(want.frame_opcode));
      compare_field("message_length", out_mon.message_length, want.message_length);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_parser();
      max_len = MAX_PAYLOAD_RST;
      expected_words.delete();
    end else begin
      if (cfg_we) max_len = cfg_data;
      if (out_mon.valid && out_mon.ready) check_word();
      if (in_mon.valid && in_mon.ready) advance_parser(in_mon.rx_byte, in_mon.restart);
    end
    outstanding <= expected_words.size();
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import wsd_pkg::*;

  localparam logic [3:0] OPC_CONT = 4'h0;
  localparam logic [3:0] OPC_TEXT = 4'h1;
  localparam logic [3:0] OPC_BIN  = 4'h2;

  localparam int LEN_SHORT = 0;
  localparam int LEN_16    = 1;
  localparam int LEN_64    = 2;

  localparam int STALL_LIMIT   = 4000;
  localparam int WORDS_PER_SET = 125;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_data;
  int          errors;
  int          outstanding;
  int          in_idle;
  int          out_idle;
  int          stall_cycles;
  int          words_sent;
  logic        need_restart;
  logic [15:0] cur_max;
  logic [7:0]  frame_bytes[$];

  wsd_in_if  in_ch ();
  wsd_out_if out_ch ();

  websocket_frame_deframer_core DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  deframe_monitor monitor_u (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .errors      (errors),
    .outstanding (outstanding)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= out_idle);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_word(input logic [7:0] b, input logic rs);
    while ($urandom_range(99) < in_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    in_ch.restart <= rs;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // stop sending and hold off until every expected word has come
  task automatic quiesce();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_max(input logic [15:0] v);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we  <= 1'b0;
    cur_max = v;
  endtask

  task automatic build_frame(input logic [3:0] opc, input logic [63:0] flen, input logic msk,
                             input int form, input logic with_body);
    logic [3:0] flags;
    flags = 4'($urandom_range(15));
    frame_bytes.delete();
    frame_bytes.push_back({flags, opc});
    case (form)
      LEN_SHORT: frame_bytes.push_back({msk, flen[6:0]});
      LEN_16: begin
        frame_bytes.push_back({msk, LEN_EXT16});
        frame_bytes.push_back(flen[15:8]);
        frame_bytes.push_back(flen[7:0]);
      end
      default: begin
        frame_bytes.push_back({msk, LEN_EXT64});
        for (int i = 7; i >= 0; i--) frame_bytes.push_back(flen[8*i +: 8]);
      end
    endcase
    if (msk) repeat (4) frame_bytes.push_back(8'($urandom));
    if (with_body) repeat (int'(flen)) frame_bytes.push_back(8'($urandom));
  endtask

  task automatic random_frame();
    logic [3:0]  opc;
    logic [63:0] flen;
    logic        msk;
    logic        stops;
    logic        rs;
    logic        restart_after;
    int          form;
    int          r;
    int          cap;
    int          nbytes;
    r = $urandom_range(99);
    if (r < 8) begin
      opc = OPC_PING;
    end else if (r < 13) begin
      opc = OPC_CLOSE;
    end else begin
      opc = 4'($urandom_range(15));
      if (opc == OPC_CLOSE || opc == OPC_PING) opc = OPC_TEXT;
    end
    cap = (int'(cur_max) + 3 < 16) ? int'(cur_max) + 3 : 16;
    r = $urandom_range(99);
    if (r < 10) flen = '0;
    else if (r < 92 || opc == OPC_PING) flen = 64'($urandom_range(cap, 1));
    else flen = {32'($urandom), 32'($urandom)} | 64'h1_0000;
    if (flen > 64'hFFFF) begin
      form = LEN_64;
    end else begin
      r = $urandom_range(99);
      form = (r < 80 && flen < 126) ? LEN_SHORT : (r < 95) ? LEN_16 : LEN_64;
    end
    msk   = 1'($urandom_range(1));
    stops = (opc == OPC_CLOSE) || (opc != OPC_PING && flen > {48'd0, cur_max});
    build_frame(opc, flen, msk, form, !stops);
    if ($urandom_range(99) < 5) begin
      // broken frame: cut short, the next one restarts the parser
      nbytes        = $urandom_range(frame_bytes.size() - 1, 1);
      restart_after = 1'b1;
    end else begin
      nbytes        = frame_bytes.size();
      restart_after = stops;
    end
    rs = need_restart || ($urandom_range(99) < 3);
    for (int i = 0; i < nbytes; i++) send_word(frame_bytes[i], (i == 0) ? rs : 1'b0);
    words_sent += nbytes;
    need_restart = restart_after;
    // parser is stopped, these words are dropped
    if (stops && nbytes == frame_bytes.size())
      repeat ($urandom_range(3)) send_word(8'($urandom), 1'b0);
    if ($urandom_range(99) < 2) quiesce();
  endtask

  initial begin
    int          target;
    logic [15:0] setting;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = '0;
    in_ch.restart = 1'b0;
    out_ch.ready  = 1'b0;
    cfg_we        = 1'b0;
    cfg_data      = '0;
    rst_n         = 1'b0;
    stall_cycles  = 0;
    words_sent    = 0;
    need_restart  = 1'b0;
    cur_max       = MAX_PAYLOAD_RST;
    in_idle       = 20;
    out_idle      = 78;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // masked text frame, all-ones key
    send_word({4'h8, OPC_TEXT}, 1'b0);
    send_word({1'b1, 7'd2}, 1'b0);
    repeat (4) send_word(8'hFF, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    // empty continuation frame
    send_word({4'h0, OPC_CONT}, 1'b0);
    send_word(8'h00, 1'b0);
    // ping with one payload byte to skip
    send_word({4'h8, OPC_PING}, 1'b0);
    send_word({1'b0, 7'd1}, 1'b0);
    send_word(8'hA5, 1'b0);
    // close stops the parser, next word is dropped
    send_word({4'h8, OPC_CLOSE}, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'h81, 1'b0);
    // restart, 64-bit length with top bit set gives oversize
    send_word({4'hF, OPC_BIN}, 1'b1);
    send_word({1'b0, LEN_EXT64}, 1'b0);
    send_word(8'h80, 1'b0);
    repeat (7) send_word(8'h00, 1'b0);
    need_restart = 1'b1;

    for (int set_no = 0; set_no < 6; set_no++) begin
      quiesce();
      case (set_no)
        0: setting = 16'd12;
        1: setting = 16'hFFFF;
        2: setting = 16'd0;
        3: setting = 16'($urandom_range(30, 1));
        4: setting = 16'd1;
        default: setting = 16'd20;
      endcase
      write_max(setting);
      if (set_no < 2) begin
        in_idle  = 20;
        out_idle <= 78;
      end else if (set_no < 4) begin
        in_idle  = 78;
        out_idle <= 20;
      end else begin
        in_idle  = 0;
        out_idle <= 0;
      end
      target = words_sent + WORDS_PER_SET;
      while (words_sent < target) random_frame();
    end

    quiesce();
    repeat (8) @(posedge clk);
    if (errors == 0 && outstanding == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
